// ===== hw/rtl/tmsp_pkg.sv =====
// Shared types and constants for the tile map scroll pager.
// Used by every module of the block; depends on nothing else.
package tmsp_pkg;

   // Fixed geometry of the screen and of the video memory.
   localparam logic [31:0] VRAM_TOP    = 32'h0600_0000;
   localparam logic [31:0] VRAM_BOTTOM = 32'h0620_0000;
   localparam logic [15:0] SCREEN_W    = 16'd256;
   localparam logic [15:0] SCREEN_H    = 16'd192;
   localparam int unsigned BLOCK_SHIFT = 11;          // 2048-byte blocks
   localparam logic [12:0] COPY_BYTES  = 13'd4096;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SCREEN_SELECT  = 3'd0;
   localparam logic [2:0] CSR_MAP_TYPE       = 3'd1;
   localparam logic [2:0] CSR_MAP_WIDTH      = 3'd2;
   localparam logic [2:0] CSR_MAP_HEIGHT     = 3'd3;
   localparam logic [2:0] CSR_MAP_BASE_BLOCK = 3'd4;
   localparam logic [2:0] CSR_SOURCE_BASE    = 3'd5;

   // Map type codes.
   localparam logic [1:0] MAP_SMALL = 2'd0;
   localparam logic [1:0] MAP_WIDE  = 2'd1;
   localparam logic [1:0] MAP_TALL  = 2'd2;
   localparam logic [1:0] MAP_LARGE = 2'd3;

   // Result kind codes.
   localparam logic RESULT_COPY    = 1'b0;
   localparam logic RESULT_OFFSETS = 1'b1;

   // What the back end has to do for one request.
   typedef enum logic [1:0] {
      JOB_OFFSETS = 2'd0,
      JOB_SINGLE  = 2'd1,
      JOB_DOUBLE  = 2'd2
   } job_type;

   typedef struct packed {
      logic        screen_select;
      logic [1:0]  map_type;
      logic [15:0] map_width;
      logic [15:0] map_height;
      logic [4:0]  map_base_block;
      logic [31:0] source_base;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] scroll_x;
      logic signed [15:0] scroll_y;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] dest_address;
      logic [31:0] source_address;
      logic [12:0] copy_length;
      logic [8:0]  horizontal_offset;
      logic [8:0]  vertical_offset;
      logic        last_result;
   } rsp_type;

   // Classified request passed from the front end to the back end.
   typedef struct packed {
      job_type    job;
      logic [7:0] blk_a;   // block x, or the single paged block
      logic [7:0] blk_b;   // block y of a large map
      logic [8:0] h_off;
      logic [8:0] v_off;
   } entry_type;

endpackage

// ===== hw/rtl/tmsp_front.sv =====
// Front end of the scroll pager: clamps a request, compares its blocks with
// the stored ones and classifies it into a job. Depends on tmsp_pkg.
module tmsp_front
   import tmsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   input  req_type   req_data,
   input  logic      queue_full,
   output logic      req_stall,
   output logic      push,
   output entry_type entry
);

   logic [7:0]  cur_x_ff, cur_x_in;
   logic [7:0]  cur_y_ff, cur_y_in;
   logic [15:0] lim_x, lim_y;
   logic [15:0] cx, cy;
   logic [7:0]  bx, by;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // Clamp limits; a map smaller than the screen clamps to zero.
   assign lim_x = (cfg.map_width > SCREEN_W) ? cfg.map_width - SCREEN_W : '0;
   assign lim_y = (cfg.map_height > SCREEN_H) ? cfg.map_height - SCREEN_H : '0;

   // Clamp each axis to the range zero to its limit.
   always_comb begin
      if (req_data.scroll_x[15]) begin
         cx = '0;
      end else if (16'(req_data.scroll_x) > lim_x) begin
         cx = lim_x;
      end else begin
         cx = 16'(req_data.scroll_x);
      end
      if (req_data.scroll_y[15]) begin
         cy = '0;
      end else if (16'(req_data.scroll_y) > lim_y) begin
         cy = lim_y;
      end else begin
         cy = 16'(req_data.scroll_y);
      end
   end

   assign bx = cx[15:8];
   assign by = cy[15:8];

   // Classify the request and work out the stored blocks that follow.
   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      entry.job   = JOB_OFFSETS;
      entry.blk_a = bx;
      entry.blk_b = by;
      entry.h_off = cx[8:0];
      entry.v_off = cy[8:0];
      unique case (cfg.map_type)
         MAP_SMALL: begin
            entry.h_off = req_data.scroll_x[8:0];
            entry.v_off = req_data.scroll_y[8:0];
         end
         MAP_WIDE: begin
            entry.h_off = {1'b0, cx[7:0]};
            if (cur_x_ff != bx) begin
               entry.job = JOB_SINGLE;
               cur_x_in  = bx;
            end
         end
         MAP_TALL: begin
            entry.v_off = {1'b0, cy[7:0]};
            entry.blk_a = by;
            if (cur_y_ff != by) begin
               entry.job = JOB_SINGLE;
               cur_y_in  = by;
            end
         end
         default: begin
            entry.h_off = {1'b0, cx[7:0]};
            entry.v_off = {1'b0, cy[7:0]};
            if (cur_x_ff != bx || cur_y_ff != by) begin
               entry.job = JOB_DOUBLE;
               cur_x_in  = bx;
               cur_y_in  = by;
            end
         end
      endcase
   end

   // Stored blocks change only when a word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else if (accept) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

endmodule

// ===== hw/rtl/tmsp_queue.sv =====
// Short job queue between the front end and the back end of the pager.
// Depends on tmsp_pkg for the entry type.
module tmsp_queue
   import tmsp_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type entry_in,
   input  logic      pop,
   output entry_type entry_out,
   output logic      not_empty,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign entry_out = entries_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== hw/rtl/tmsp_back.sv =====
// Back end of the scroll pager: takes jobs from the queue and emits the copy
// requests and the offsets word, one per cycle while the receiver does not stall. Depends on tmsp_pkg.
module tmsp_back
   import tmsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      job_valid,
   input  entry_type job_entry,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic        work_valid_ff, work_valid_in;
   job_type     work_job_ff;
   logic [8:0]  work_h_ff, work_v_ff;
   logic [27:0] work_off_ff, work_off_in;
   logic [1:0]  work_idx_ff, work_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [8:0]  row_blocks;
   logic [19:0] row_bytes;
   logic [16:0] blk_index;
   logic [1:0]  copies;
   logic [31:0] vram_base;
   logic        out_free, emit, last_emit, second;

   // Blocks per map row, rounded up, and the row size in bytes.
   assign row_blocks = {1'b0, cfg.map_width[15:8]} + 9'(|cfg.map_width[7:0]);
   assign row_bytes  = {row_blocks, 11'b0};

   assign vram_base = (cfg.screen_select ? VRAM_BOTTOM : VRAM_TOP)
                    + {16'b0, cfg.map_base_block, 11'b0};

   always_comb begin
      unique case (work_job_ff)
         JOB_SINGLE: copies = 2'd1;
         JOB_DOUBLE: copies = 2'd2;
         default:    copies = 2'd0;
      endcase
   end

   // Handshake between the work register, the queue and the output word.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = work_valid_ff && out_free;
   assign last_emit = emit && (work_idx_ff == copies);
   assign pop       = job_valid && (!work_valid_ff || last_emit);
   assign second    = work_idx_ff[0];

   // Source offset of the first copy, found as the job is loaded.
   always_comb begin
      blk_index = 17'(job_entry.blk_b) * 17'(row_blocks) + 17'(job_entry.blk_a);
      if (job_entry.job == JOB_DOUBLE) begin
         work_off_in = {blk_index, 11'b0};
      end else begin
         work_off_in = {9'b0, job_entry.blk_a, 11'b0};
      end
   end

   always_comb begin
      work_valid_in = work_valid_ff;
      work_idx_in   = work_idx_ff;
      if (pop) begin
         work_valid_in = 1'b1;
         work_idx_in   = '0;
      end else if (last_emit) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         work_idx_in = work_idx_ff + 1'b1;
      end
   end

   // Build the next result word.
   always_comb begin
      rsp_data_in = '0;
      if (work_idx_ff == copies) begin
         rsp_data_in.result_kind       = RESULT_OFFSETS;
         rsp_data_in.horizontal_offset = work_h_ff;
         rsp_data_in.vertical_offset   = work_v_ff;
         rsp_data_in.last_result       = 1'b1;
      end else begin
         rsp_data_in.result_kind    = RESULT_COPY;
         rsp_data_in.dest_address   = vram_base + (second ? 32'(COPY_BYTES) : 32'd0);
         rsp_data_in.source_address = cfg.source_base + 32'(work_off_ff)
                                    + (second ? 32'(row_bytes) : 32'd0);
         rsp_data_in.copy_length    = COPY_BYTES;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         work_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         work_idx_ff   <= work_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         work_job_ff <= job_entry.job;
         work_h_ff   <= job_entry.h_off;
         work_v_ff   <= job_entry.v_off;
         work_off_ff <= work_off_in;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/tile_map_scroll_pager_unit.sv =====
// Scroll pager for one background layer of a tile display.
// Request channel (req_): one word carries a signed scroll position in x and y.
// Result channel (rsp_): for each request, zero to two copy requests from the
// map in main memory into video memory, then one word with the hardware
// offsets, marked by last_result. A word moves when valid is high and stall
// is low. Configuration (csr_) takes one register per cycle; the user must
// write it only while idle; the block does not enforce this. A request passes
// the job queue and the work register before its first result word is out.
// The back end emits one result word per cycle unless the receiver stalls;
// the front end takes a new request every cycle while the job queue has room.
// Reset clears the stored blocks, the job queue and the output word, and sets
// the registers to a 256 by 192 small map at the top screen.
// When the receiver stalls, the output word holds; the queue then fills and
// req_stall rises once QUEUE_DEPTH jobs wait.
// Depends on tmsp_pkg, tmsp_front, tmsp_queue and tmsp_back.
module tile_map_scroll_pager_unit
   import tmsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type   cfg_ff;
   logic      push, pop, queue_full, job_valid;
   entry_type front_entry, job_entry;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_select  <= 1'b0;
         cfg_ff.map_type       <= MAP_SMALL;
         cfg_ff.map_width      <= SCREEN_W;
         cfg_ff.map_height     <= SCREEN_H;
         cfg_ff.map_base_block <= '0;
         cfg_ff.source_base    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCREEN_SELECT:  cfg_ff.screen_select  <= csr_wdata[0];
            CSR_MAP_TYPE:       cfg_ff.map_type       <= csr_wdata[1:0];
            CSR_MAP_WIDTH:      cfg_ff.map_width      <= csr_wdata[15:0];
            CSR_MAP_HEIGHT:     cfg_ff.map_height     <= csr_wdata[15:0];
            CSR_MAP_BASE_BLOCK: cfg_ff.map_base_block <= csr_wdata[4:0];
            CSR_SOURCE_BASE:    cfg_ff.source_base    <= csr_wdata;
            default: ;
         endcase
      end
   end

   tmsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .entry      (front_entry)
   );

   tmsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (front_entry),
      .pop       (pop),
      .entry_out (job_entry),
      .not_empty (job_valid),
      .full      (queue_full)
   );

   tmsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_entry (job_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/scroll_page_checker.sv =====
// Checker for the tile map scroll pager: watches the request, result and register ports,
// predicts the result words of every accepted request and compares them in order.
// Depends on tmsp_pkg for the word types, the register indexes and the fixed geometry.
`timescale 1ns / 1ps

module scroll_page_checker
   import tmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          pending_words,
   output int          fail_count
);

   // Shadow of the registers and of the stored blocks.
   cfg_type    map_cfg;
   logic [7:0] shown_block_x;
   logic [7:0] shown_block_y;
   rsp_type    expected_words[$];
   int         errors = 0;

   initial pending_words = 0;
   assign fail_count = errors;

   // One line per mismatch, and one more on the count.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Clamp a scroll position to the range the map allows on one axis.
   function automatic logic [31:0] clamp_axis(input int pos, input logic [15:0] size,
                                              input logic [15:0] view);
      int limit;
      limit = (size > view) ? int'(size) - int'(view) : 0;
      if (pos < 0) pos = 0;
      if (pos > limit) pos = limit;
      return 32'(pos);
   endfunction

   // Work out the copy words and the offsets word for one scroll request.
   function automatic void page_request(input req_type w);
      logic [31:0] cx, cy, vbase, rowsize, start;
      logic [7:0]  bx, by;
      rsp_type     copy_word, offs_word;
      copy_word = '0;
      offs_word = '0;
      offs_word.result_kind = RESULT_OFFSETS;
      offs_word.last_result = 1'b1;
      copy_word.result_kind = RESULT_COPY;
      copy_word.copy_length = COPY_BYTES;
      vbase = (map_cfg.screen_select ? VRAM_BOTTOM : VRAM_TOP)
            + (32'(map_cfg.map_base_block) << BLOCK_SHIFT);
      copy_word.dest_address = vbase;
      cx = clamp_axis($signed(w.scroll_x), map_cfg.map_width, SCREEN_W);
      cy = clamp_axis($signed(w.scroll_y), map_cfg.map_height, SCREEN_H);
      bx = cx[15:8];
      by = cy[15:8];
      case (map_cfg.map_type)
         MAP_SMALL: begin
            offs_word.horizontal_offset = w.scroll_x[8:0];
            offs_word.vertical_offset   = w.scroll_y[8:0];
         end
         MAP_WIDE: begin
            if (shown_block_x != bx) begin
               copy_word.source_address = map_cfg.source_base + (32'(bx) << BLOCK_SHIFT);
               expected_words.push_back(copy_word);
               shown_block_x = bx;
            end
            offs_word.horizontal_offset = {1'b0, cx[7:0]};
            offs_word.vertical_offset   = cy[8:0];
         end
         MAP_TALL: begin
            if (shown_block_y != by) begin
               copy_word.source_address = map_cfg.source_base + (32'(by) << BLOCK_SHIFT);
               expected_words.push_back(copy_word);
               shown_block_y = by;
            end
            offs_word.horizontal_offset = cx[8:0];
            offs_word.vertical_offset   = {1'b0, cy[7:0]};
         end
         default: begin
            // A large map pages two rows of blocks, one copy per row.
            rowsize = ((32'(map_cfg.map_width) + 32'd255) >> 8) << BLOCK_SHIFT;
            if (shown_block_x != bx || shown_block_y != by) begin
               start = 32'(by) * rowsize + (32'(bx) << BLOCK_SHIFT);
               copy_word.source_address = map_cfg.source_base + start;
               expected_words.push_back(copy_word);
               copy_word.dest_address   = vbase + 32'(COPY_BYTES);
               copy_word.source_address = map_cfg.source_base + start + rowsize;
               expected_words.push_back(copy_word);
               shown_block_x = bx;
               shown_block_y = by;
            end
            offs_word.horizontal_offset = {1'b0, cx[7:0]};
            offs_word.vertical_offset   = {1'b0, cy[7:0]};
         end
      endcase
      expected_words.push_back(offs_word);
   endfunction

   // All ports are sampled at the rising edge, before the drivers update them.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         map_cfg = '{screen_select: 1'b0, map_type: MAP_SMALL, map_width: SCREEN_W,
                     map_height: SCREEN_H, map_base_block: 5'd0, source_base: 32'd0};
         shown_block_x = '0;
         shown_block_y = '0;
         expected_words.delete();
      end else begin
         // Register writes land in the shadow at the same edge as in the block.
         if (csr_write) begin
            case (csr_index)
               CSR_SCREEN_SELECT:  map_cfg.screen_select  = csr_wdata[0];
               CSR_MAP_TYPE:       map_cfg.map_type       = csr_wdata[1:0];
               CSR_MAP_WIDTH:      map_cfg.map_width      = csr_wdata[15:0];
               CSR_MAP_HEIGHT:     map_cfg.map_height     = csr_wdata[15:0];
               CSR_MAP_BASE_BLOCK: map_cfg.map_base_block = csr_wdata[4:0];
               CSR_SOURCE_BASE:    map_cfg.source_base    = csr_wdata;
               default: ;
            endcase
         end
         // Compare each accepted result word with the oldest expected one.
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("result word with nothing expected",
                               rsp_data.source_address, 32'd0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.result_kind !== want.result_kind)
                  report_mismatch("result_kind", 32'(rsp_data.result_kind),
                                  32'(want.result_kind));
               if (rsp_data.dest_address !== want.dest_address)
                  report_mismatch("dest_address", rsp_data.dest_address,
                                  want.dest_address);
               if (rsp_data.source_address !== want.source_address)
                  report_mismatch("source_address", rsp_data.source_address,
                                  want.source_address);
               if (rsp_data.copy_length !== want.copy_length)
                  report_mismatch("copy_length", 32'(rsp_data.copy_length),
                                  32'(want.copy_length));
               if (rsp_data.horizontal_offset !== want.horizontal_offset)
                  report_mismatch("horizontal_offset", 32'(rsp_data.horizontal_offset),
                                  32'(want.horizontal_offset));
               if (rsp_data.vertical_offset !== want.vertical_offset)
                  report_mismatch("vertical_offset", 32'(rsp_data.vertical_offset),
                                  32'(want.vertical_offset));
               if (rsp_data.last_result !== want.last_result)
                  report_mismatch("last_result", 32'(rsp_data.last_result),
                                  32'(want.last_result));
            end
         end
         // Predict the words of a request accepted at this edge.
         if (req_valid && !req_stall)
            page_request(req_data);
      end
      pending_words <= expected_words.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the scroll pager bench: clock, reset, request and register stimulus,
// receiver stalls, watchdog and verdict. Depends on tmsp_pkg, the block and scroll_page_checker.
`timescale 1ns / 1ps

module testbench;
   import tmsp_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_LIMIT   = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_SCREEN_SELECT;
   logic [31:0] csr_wdata = '0;
   int          pending_words;
   int          fail_count;
   logic        quiet = 1'b1;
   int          stall_left = 0;
   int          run_left = 0;
   int          idle_cycles = 0;

   always #1 clock = ~clock;

   tile_map_scroll_pager_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   scroll_page_checker pager_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending_words(pending_words), .fail_count(fail_count)
   );

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Map size on one axis, with the screen size, zero and the top among the picks.
   function automatic logic [15:0] pick_size(input int view);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return 16'd0;
      if (r < 12) return 16'($urandom_range(1, view - 1));
      if (r < 20) return 16'(view);
      if (r < 27) return 16'hFFFF;
      if (r < 35) return 16'($urandom());
      return 16'($urandom_range(view + 1, 2048));
   endfunction

   // Scroll position: mostly inside the map so that blocks change.
   function automatic logic [15:0] pick_scroll(input int size);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 16'($urandom_range(0, (size < 32767) ? size : 32767));
      if (r < 75) return 16'($urandom());
      if (r < 85) return 16'(0 - int'($urandom_range(1, 300)));
      if (r < 92) return 16'h7FFF;
      return 16'h8000;
   endfunction

   // Unused high bits of a register write carry random junk.
   function automatic logic [31:0] with_junk(input logic [31:0] v, input int bits);
      return v | (($urandom() >> bits) << bits);
   endfunction

   // The receiver stalls in random bursts, except in quiet stretches.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         run_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (run_left > 0) begin
            run_left--;
         end else begin
            stall_left = pick_gap();
            run_left = $urandom_range(0, 6);
         end
      end
   end

   // Watchdog on cycles in which no word and no register write moves.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("tile_map_scroll_pager_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one request word and wait until it is taken.
   task automatic send_scroll(input logic [15:0] x, input logic [15:0] y);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{scroll_x: x, scroll_y: y};
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every expected result word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Write the whole register set, one register per cycle.
   task automatic apply_map(input logic sel, input logic [1:0] mtype,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [4:0] blk, input logic [31:0] src);
      write_reg(CSR_SCREEN_SELECT, with_junk(32'(sel), 1));
      write_reg(CSR_MAP_TYPE, with_junk(32'(mtype), 2));
      write_reg(CSR_MAP_WIDTH, with_junk(32'(w), 16));
      write_reg(CSR_MAP_HEIGHT, with_junk(32'(h), 16));
      write_reg(CSR_MAP_BASE_BLOCK, with_junk(32'(blk), 5));
      write_reg(CSR_SOURCE_BASE, src);
      csr_write <= 1'b0;
   endtask

   initial begin
      int          sent;
      int          phase_len;
      logic [15:0] map_w;
      logic [15:0] map_h;
      logic [31:0] src;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small map after reset: raw positions, sign bits and extremes.
      send_scroll(16'd0, 16'd0);
      send_scroll(16'h7FFF, 16'h8000);
      send_scroll(16'hFFFF, 16'hFFFF);
      send_scroll(16'h8000, 16'h7FFF);
      send_scroll(16'h0155, 16'h00AA);
      drain();

      // Wide map on the bottom screen, top block index, source base that wraps.
      apply_map(1'b1, MAP_WIDE, 16'hFFFF, 16'hFFFF, 5'd31, 32'hFFFF_F000);
      send_scroll(16'hFFFB, 16'd10);
      send_scroll(16'd300, 16'd1000);
      send_scroll(16'd300, 16'hFFF9);
      send_scroll(16'h7FFF, 16'h7FFF);
      drain();

      // Tall map whose height barely exceeds the screen: clamping at the top limit.
      apply_map(1'b0, MAP_TALL, 16'd256, 16'd200, 5'd0, 32'd0);
      send_scroll(16'd40, 16'd5000);
      send_scroll(16'hFFFD, 16'hFFFD);
      drain();
      apply_map(1'b0, MAP_TALL, 16'd300, 16'd1000, 5'd3, 32'h0000_1000);
      send_scroll(16'd7, 16'd1000);
      send_scroll(16'd7, 16'd900);
      drain();

      // Large map of zero size: both limits are zero and the row size is zero.
      apply_map(1'b1, MAP_LARGE, 16'd0, 16'd0, 5'd9, 32'h0000_0040);
      send_scroll(16'd1000, 16'd1000);
      drain();

      // Large map smaller than the screen.
      apply_map(1'b0, MAP_LARGE, 16'd100, 16'd100, 5'd5, 32'h0000_0100);
      send_scroll(16'd500, 16'd500);
      send_scroll(16'hFE0C, 16'hFE0C);
      drain();

      // Full-size large map: double copies, a repeat without copies, back to zero.
      apply_map(1'b1, MAP_LARGE, 16'hFFFF, 16'hFFFF, 5'd17, 32'h8000_0000);
      send_scroll(16'd600, 16'd700);
      send_scroll(16'd600, 16'd700);
      send_scroll(16'd600, 16'd2000);
      send_scroll(16'hFFFF, 16'hFFFF);
      send_scroll(16'h7FFF, 16'h7FFF);
      drain();

      // Random phases, each under a fresh register set, with idling on both sides.
      quiet <= 1'b0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         map_w = pick_size(256);
         map_h = pick_size(192);
         case ($urandom_range(0, 9))
            0:       src = 32'd0;
            1:       src = 32'hFFFF_FFFF;
            default: src = $urandom();
         endcase
         apply_map(1'($urandom()), 2'($urandom()), map_w, map_h, 5'($urandom()), src);
         phase_len = $urandom_range(15, 50);
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 99) < 3) drain();
            send_scroll(pick_scroll(int'(map_w)), pick_scroll(int'(map_h)));
            sent++;
         end
         drain();
      end

      // Let any stray word show up before the verdict.
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("tile_map_scroll_pager_unit: match");
      else
         $display("tile_map_scroll_pager_unit: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tmsp_pkg.sv
hw/rtl/tmsp_front.sv
hw/rtl/tmsp_queue.sv
hw/rtl/tmsp_back.sv
hw/rtl/tile_map_scroll_pager_unit.sv
bench/scroll_page_checker.sv
bench/testbench.sv
